@@ rtl/ltd_pkg.sv @@
// Shared types and constants for the location table decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ltd_pkg;

   localparam int LINE_BITS_DEFAULT = 32;
   localparam int OUT_BITS          = 32;
   localparam int ACCUM_BITS        = 64;
   localparam int CHUNK_BITS        = 6;
   localparam int VARINT_CHUNKS     = 11;   // chunks kept before saturation

   // header form codes
   localparam int FORM_SHORT_LAST  = 9;
   localparam int FORM_ONE_LINE_LO = 10;
   localparam int FORM_ONE_LINE_HI = 12;
   localparam int FORM_NO_COLUMN   = 13;
   localparam int FORM_LONG        = 14;
   localparam int FORM_NO_LOCATION = 15;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SHORT,
      PH_COL_A,
      PH_COL_B,
      PH_VARINT
   } phase_type;

   // which varint of a long or no-column entry is being read
   typedef enum logic [1:0] {
      FLD_LINE,
      FLD_END_LINE,
      FLD_START_COL,
      FLD_END_COL
   } field_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       table_start;
   } req_type;

   typedef struct packed {
      logic [31:0] start_line;
      logic [31:0] end_line;
      logic [31:0] start_column;
      logic [31:0] end_column;
      logic [3:0]  instr_count;
      logic        has_location;
      logic        has_columns;
      logic        format_error;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } req_beat_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_beat_type;

endpackage

`default_nettype wire

@@ rtl/ltd_in_stage.sv @@
// Input register of the location table decoder: holds one accepted byte beat.
// Depends on ltd_pkg.
`default_nettype none

module ltd_in_stage
   import ltd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   input  wire logic         consume,
   output req_beat_type      beat
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || consume;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/ltd_parser.sv @@
// Parse step of the location table decoder: first_line register, running line,
// partial entry state and the one-byte decode. Depends on ltd_pkg.
`default_nettype none

module ltd_parser
   import ltd_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wen,
   input  wire logic [31:0]   csr_wdata,
   input  wire logic          step,
   input  wire req_type       in_data,
   output rsp_beat_type       res
);

   logic [31:0]            first_line_ff;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   phase_type              phase_ff, phase_in;
   logic [3:0]             form_ff, form_in;
   logic [2:0]             length_ff, length_in;
   field_type              field_ff, field_in;
   logic [ACCUM_BITS-1:0]  accum_ff, accum_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [LINE_BITS-1:0]   held_end_ff, held_end_in;
   logic [31:0]            held_sc_ff, held_sc_in;
   logic                   error_ff, error_in;

   logic [7:0]             b;
   logic [ACCUM_BITS-1:0]  first_wide;
   logic [LINE_BITS-1:0]   line_base;
   phase_type              phase_eff;
   logic [6:0]             shamt;
   logic [ACCUM_BITS-1:0]  chunk_wide, value, half;
   logic                   saturate;
   logic [LINE_BITS-1:0]   half_line, delta, line_delta_sum;
   logic [6:0]             short_sc;
   logic [7:0]             short_ec;

   logic                   emit;
   logic [LINE_BITS-1:0]   e_sl, e_el;
   logic [31:0]            e_sc, e_ec;
   logic                   e_loc, e_cols;
   logic [ACCUM_BITS-1:0]  sl_wide, el_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_line_ff <= '0;
      end else if (csr_wen) begin
         first_line_ff <= csr_wdata;
      end
   end

   assign b          = in_data.data_byte;
   assign first_wide = ACCUM_BITS'(first_line_ff);
   assign line_base  = in_data.table_start ? first_wide[LINE_BITS-1:0] : line_ff;
   assign phase_eff  = in_data.table_start ? PH_HEADER : phase_ff;

   // varint chunk placement and saturation
   assign shamt      = 7'(cnt_ff) * 7'(CHUNK_BITS);
   assign chunk_wide = ACCUM_BITS'(b[5:0]) << shamt;
   assign saturate   = (cnt_ff >= 4'(VARINT_CHUNKS));
   assign value      = saturate ? '1 : (accum_ff | chunk_wide);

   // zigzag-style signed delta: sign in bit 0
   assign half           = value >> 1;
   assign half_line      = half[LINE_BITS-1:0];
   assign delta          = value[0] ? (LINE_BITS'(0) - half_line) : half_line;
   assign line_delta_sum = line_base + delta;

   assign short_sc = {form_ff, b[6:4]};
   assign short_ec = 8'(short_sc) + 8'(b[3:0]);

   always_comb begin
      line_in     = line_base;
      phase_in    = phase_eff;
      form_in     = form_ff;
      length_in   = length_ff;
      field_in    = field_ff;
      accum_in    = accum_ff;
      cnt_in      = cnt_ff;
      held_end_in = held_end_ff;
      held_sc_in  = held_sc_ff;
      error_in    = error_ff;
      emit        = 1'b0;
      e_sl        = '0;
      e_el        = '0;
      e_sc        = '0;
      e_ec        = '0;
      e_loc       = 1'b1;
      e_cols      = 1'b1;

      case (phase_eff)
         PH_HEADER: begin
            length_in = b[2:0];
            form_in   = b[6:3];
            error_in  = 1'b0;
            field_in  = FLD_LINE;
            accum_in  = '0;
            cnt_in    = '0;
            if (form_in <= 4'(FORM_SHORT_LAST)) begin
               phase_in = PH_SHORT;
            end else if (form_in <= 4'(FORM_ONE_LINE_HI)) begin
               line_in  = line_base + LINE_BITS'(form_in - 4'(FORM_ONE_LINE_LO));
               phase_in = PH_COL_A;
            end else if (form_in <= 4'(FORM_LONG)) begin
               phase_in = PH_VARINT;
            end else begin
               // no-location entry: record right away, line untouched
               emit   = 1'b1;
               e_loc  = 1'b0;
               e_cols = 1'b0;
            end
         end
         PH_SHORT: begin
            emit = 1'b1;
            e_sl = line_base;
            e_el = line_base;
            e_sc = 32'(short_sc);
            e_ec = 32'(short_ec);
         end
         PH_COL_A: begin
            held_sc_in = 32'(b);
            phase_in   = PH_COL_B;
         end
         PH_COL_B: begin
            emit = 1'b1;
            e_sl = line_base;
            e_el = line_base;
            e_sc = held_sc_ff;
            e_ec = 32'(b);
         end
         PH_VARINT: begin
            error_in = error_ff | saturate;
            if (b[6]) begin
               accum_in = value;
               cnt_in   = saturate ? cnt_ff : cnt_ff + 4'd1;
            end else begin
               accum_in = '0;
               cnt_in   = '0;
               case (field_ff)
                  FLD_LINE: begin
                     line_in = line_delta_sum;
                     if (form_ff == 4'(FORM_NO_COLUMN)) begin
                        emit   = 1'b1;
                        e_sl   = line_delta_sum;
                        e_el   = line_delta_sum;
                        e_cols = 1'b0;
                     end else begin
                        field_in = FLD_END_LINE;
                     end
                  end
                  FLD_END_LINE: begin
                     held_end_in = line_base + value[LINE_BITS-1:0];
                     field_in    = FLD_START_COL;
                  end
                  FLD_START_COL: begin
                     held_sc_in = value[31:0];
                     field_in   = FLD_END_COL;
                  end
                  FLD_END_COL: begin
                     emit = 1'b1;
                     e_sl = line_base;
                     e_el = held_end_ff;
                     e_sc = held_sc_ff;
                     e_ec = value[31:0];
                  end
                  default: begin
                     field_in = FLD_LINE;
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      if (emit) begin
         phase_in = PH_HEADER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= '0;
         phase_ff    <= PH_HEADER;
         form_ff     <= '0;
         length_ff   <= '0;
         field_ff    <= FLD_LINE;
         accum_ff    <= '0;
         cnt_ff      <= '0;
         held_end_ff <= '0;
         held_sc_ff  <= '0;
         error_ff    <= 1'b0;
      end else if (step) begin
         line_ff     <= line_in;
         phase_ff    <= phase_in;
         form_ff     <= form_in;
         length_ff   <= length_in;
         field_ff    <= field_in;
         accum_ff    <= accum_in;
         cnt_ff      <= cnt_in;
         held_end_ff <= held_end_in;
         held_sc_ff  <= held_sc_in;
         error_ff    <= error_in;
      end
   end

   assign sl_wide = ACCUM_BITS'(e_sl);
   assign el_wide = ACCUM_BITS'(e_el);

   assign res.valid             = step && emit;
   assign res.data.start_line   = sl_wide[OUT_BITS-1:0];
   assign res.data.end_line     = el_wide[OUT_BITS-1:0];
   assign res.data.start_column = e_sc;
   assign res.data.end_column   = e_ec;
   assign res.data.instr_count  = 4'(length_in) + 4'd1;
   assign res.data.has_location = e_loc;
   assign res.data.has_columns  = e_cols;
   assign res.data.format_error = error_in;

endmodule

`default_nettype wire

@@ rtl/ltd_out_stage.sv @@
// Result register of the location table decoder: holds one record beat.
// Depends on ltd_pkg.
`default_nettype none

module ltd_out_stage
   import ltd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rsp_beat_type  res,
   output logic               free,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_type            rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      if (res.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // res.valid only rises when free is high
   always_ff @(posedge clock) begin
      if (res.valid) begin
         data_ff <= res.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/location_table_decoder_unit.sv @@
// Location table decoder top level: input register, parse step, result register.
// Depends on ltd_pkg, ltd_in_stage, ltd_parser and ltd_out_stage.
`default_nettype none

// Takes one location-table byte per beat on req_ and gives one location record
// on rsp_ for each finished entry (short, one-line, no-column, long, and a
// record flagged with has_location low for the no-location form). A byte with
// table_start set reloads the running line from first_line and drops any
// partial entry. Throughput is one byte per clock while rsp_ready is high; a
// record's last byte waits in the input register until the parse step decodes
// it and writes the record into the result register that drives rsp_.
// Backpressure on rsp_ready stalls the parse step and then req_ready.
// first_line is written through csr_wen and csr_wdata and must only change
// while the decoder is idle. LINE_BITS sets the width of the running line
// arithmetic; reported lines are its low 32 bits.
module location_table_decoder_unit
   import ltd_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wen,
   input  wire logic [31:0] csr_wdata
);

   req_beat_type in_beat;
   rsp_beat_type res;
   logic         out_free;
   logic         step;

   assign step = in_beat.valid && out_free;

   ltd_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .consume   (step),
      .beat      (in_beat)
   );

   ltd_parser #(
      .LINE_BITS (LINE_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .step      (step),
      .in_data   (in_beat.data),
      .res       (res)
   );

   ltd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/ltd_checker.sv @@
// Port-level checks for location_table_decoder_unit, bound to the top level.
// Depends on ltd_pkg.
`default_nettype none

module ltd_checker
   import ltd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("record beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled record beat changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.instr_count != 4'd0 && rsp_data.instr_count <= 4'd8)
      else $error("instr_count out of range");

   a_no_location: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_location |->
         !rsp_data.has_columns && !rsp_data.format_error &&
         rsp_data.start_line == '0 && rsp_data.end_line == '0 &&
         rsp_data.start_column == '0 && rsp_data.end_column == '0)
      else $error("no-location record carries data");

   a_no_columns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_location && !rsp_data.has_columns |->
         rsp_data.start_column == '0 && rsp_data.end_column == '0 &&
         rsp_data.start_line == rsp_data.end_line)
      else $error("no-column record malformed");

endmodule

bind location_table_decoder_unit ltd_checker u_ltd_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for location_table_decoder_unit: directed table, then random entry streams.
// Holds its own byte-level decoder of the table format and scoreboards records in order.
// Depends on ltd_pkg and the decoder RTL only.
`default_nettype none

module tb_top;
   import ltd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 6;     // two-stage pipe plus margin
   localparam int QUIET_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 80;
   localparam int MAX_REPORTS   = 10;
   localparam int VARINT_BITS   = VARINT_CHUNKS * CHUNK_BITS;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       table_start;
      logic       typed;      // record below is written out by hand
      rsp_type    record;
   } stim_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wen     = 1'b0;
   logic [31:0] csr_wdata = '0;

   // decoder mirror
   logic [31:0] cfg_first_line = '0;
   logic [31:0] line_q         = '0;
   phase_type   phase_q        = PH_HEADER;
   logic [3:0]  form_q         = '0;
   logic [2:0]  len_q          = '0;
   field_type   fld_q          = FLD_LINE;
   logic [63:0] accum_q        = '0;
   int          shift_q        = 0;
   logic [31:0] end_line_q     = '0;
   logic [31:0] start_col_q    = '0;
   logic        err_q          = 1'b0;

   rsp_type      expected_records[$];
   stim_row_type pending_rows[$];
   bit      start_next     = 1'b0;
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   int      send_idle_pct  = 0;
   int      rsp_idle_pct   = 0;
   bit      hold_request   = 1'b0;
   bit      hold_done      = 1'b0;
   int      hold_left      = 0;

   localparam int DIRECTED_ROWS = 29;
   stim_row_type directed_tab [DIRECTED_ROWS] = '{
      // no-location entry, 8 units, right at table start
      '{8'h7F, 1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 4'd8, 1'b0, 1'b0, 1'b0}},
      // short form 0, widest column nibbles
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'd22, 4'd1, 1'b1, 1'b1, 1'b0}},
      // short form 9
      '{8'h4D, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // one-line form 12: line +2 wraps past the top
      '{8'h63, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      // no-column form with a varint one byte too long: saturates, flags error
      '{8'h68, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h3F, 1'b0, 1'b0, '0},
      // long form: -1, end delta 133 over two chunks, columns 10..20
      '{8'h70, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h45, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b0, '0},
      '{8'h94, 1'b0, 1'b0, '0},
      // partial one-line entry cut off by a new table
      '{8'h58, 1'b0, 1'b0, '0},
      '{8'hF8, 1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 4'd1, 1'b0, 1'b0, 1'b0}}
   };

   location_table_decoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic rsp_type make_record(logic [31:0] sl, logic [31:0] el,
                                           logic [31:0] sc, logic [31:0] ec,
                                           logic loc, logic cols);
      rsp_type rec;
      rec.start_line   = sl;
      rec.end_line     = el;
      rec.start_column = sc;
      rec.end_column   = ec;
      rec.instr_count  = {1'b0, len_q} + 4'd1;
      rec.has_location = loc;
      rec.has_columns  = cols;
      rec.format_error = err_q;
      return rec;
   endfunction

   task automatic decode_byte(input req_type beat, output bit produced, output rsp_type rec);
      logic [7:0]  b;
      logic [63:0] v;
      logic [63:0] delta;
      logic [31:0] sc;
      b        = beat.data_byte;
      produced = 1'b0;
      rec      = '0;
      if (beat.table_start) begin
         line_q  = cfg_first_line;
         phase_q = PH_HEADER;
      end
      case (phase_q)
         PH_HEADER: begin
            len_q   = b[2:0];
            form_q  = b[6:3];
            err_q   = 1'b0;
            fld_q   = FLD_LINE;
            accum_q = '0;
            shift_q = 0;
            if (form_q <= FORM_SHORT_LAST) begin
               phase_q = PH_SHORT;
            end else if (form_q <= FORM_ONE_LINE_HI) begin
               line_q  = line_q + 32'(form_q - FORM_ONE_LINE_LO);
               phase_q = PH_COL_A;
            end else if (form_q <= FORM_LONG) begin
               phase_q = PH_VARINT;
            end else begin
               rec      = make_record('0, '0, '0, '0, 1'b0, 1'b0);
               produced = 1'b1;
            end
         end
         PH_SHORT: begin
            sc       = 32'(form_q) * 8 + 32'(b[6:4]);
            rec      = make_record(line_q, line_q, sc, sc + 32'(b[3:0]), 1'b1, 1'b1);
            produced = 1'b1;
            phase_q  = PH_HEADER;
         end
         PH_COL_A: begin
            start_col_q = 32'(b);
            phase_q     = PH_COL_B;
         end
         PH_COL_B: begin
            rec      = make_record(line_q, line_q, start_col_q, 32'(b), 1'b1, 1'b1);
            produced = 1'b1;
            phase_q  = PH_HEADER;
         end
         PH_VARINT: begin
            if (shift_q < VARINT_BITS) begin
               accum_q = accum_q | (64'(b[5:0]) << shift_q);
               shift_q = shift_q + CHUNK_BITS;
            end else begin
               err_q   = 1'b1;
               accum_q = '1;
            end
            if (!b[6]) begin
               v       = accum_q;
               accum_q = '0;
               shift_q = 0;
               case (fld_q)
                  FLD_LINE: begin
                     // zigzag sign in bit 0
                     delta  = v[0] ? (64'd0 - (v >> 1)) : (v >> 1);
                     line_q = line_q + delta[31:0];
                     if (form_q == FORM_NO_COLUMN) begin
                        rec      = make_record(line_q, line_q, '0, '0, 1'b1, 1'b0);
                        produced = 1'b1;
                        phase_q  = PH_HEADER;
                     end else begin
                        fld_q = FLD_END_LINE;
                     end
                  end
                  FLD_END_LINE: begin
                     end_line_q = line_q + v[31:0];
                     fld_q      = FLD_START_COL;
                  end
                  FLD_START_COL: begin
                     start_col_q = v[31:0];
                     fld_q       = FLD_END_COL;
                  end
                  default: begin
                     rec      = make_record(line_q, end_line_q, start_col_q, v[31:0],
                                            1'b1, 1'b1);
                     produced = 1'b1;
                     phase_q  = PH_HEADER;
                  end
               endcase
            end
         end
         default: phase_q = PH_HEADER;
      endcase
   endtask

   // random stimulus building
   task automatic push_byte(input logic [7:0] b);
      stim_row_type r;
      r             = '0;
      r.data_byte   = b;
      r.table_start = start_next;
      start_next    = 1'b0;
      pending_rows.push_back(r);
   endtask

   task automatic push_varint(input int chunks);
      logic [7:0] b;
      for (int k = 0; k < chunks; k++) begin
         b    = 8'($urandom);
         b[6] = (k != chunks - 1);
         push_byte(b);
      end
   endtask

   function automatic int varint_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 11);
      return $urandom_range(12, 14);   // past saturation
   endfunction

   function automatic logic [7:0] header_byte(input int form);
      return {1'($urandom), 4'(form), 3'($urandom)};
   endfunction

   task automatic queue_entry();
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 4) start_next = 1'b1;
      if (pick < 30) begin
         push_byte(header_byte($urandom_range(0, FORM_SHORT_LAST)));
         push_byte(8'($urandom));
      end else if (pick < 50) begin
         push_byte(header_byte($urandom_range(FORM_ONE_LINE_LO, FORM_ONE_LINE_HI)));
         push_byte(8'($urandom));
         push_byte(8'($urandom));
      end else if (pick < 65) begin
         push_byte(header_byte(FORM_NO_COLUMN));
         push_varint(varint_length());
      end else if (pick < 85) begin
         push_byte(header_byte(FORM_LONG));
         for (int f = 0; f < 4; f++) push_varint(varint_length());
      end else if (pick < 92) begin
         push_byte(header_byte(FORM_NO_LOCATION));
      end else if (pick < 97) begin
         for (int n = $urandom_range(1, 3); n > 0; n--) push_byte(8'($urandom));
      end else begin
         // entry abandoned by a fresh table
         push_byte(header_byte($urandom_range(FORM_NO_COLUMN, FORM_LONG)));
         for (int n = $urandom_range(1, 4); n > 0; n--) push_byte(8'($urandom));
         start_next = 1'b1;
      end
   endtask

   // driving
   task automatic send_row(input stim_row_type r);
      req_type beat;
      bit      produced;
      rsp_type rec;
      beat.data_byte   = r.data_byte;
      beat.table_start = r.table_start;
      decode_byte(beat, produced, rec);
      if (r.typed) expected_records.push_back(r.record);
      else if (produced) expected_records.push_back(rec);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_records.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_first_line(input logic [31:0] value);
      csr_wen        <= 1'b1;
      csr_wdata      <= value;
      cfg_first_line  = value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic run_phase(input int items, input logic [31:0] line0, input int s_idle,
                            input int r_idle, input bit with_hold);
      int sent;
      drain();
      send_idle_pct  = s_idle;
      rsp_idle_pct  <= r_idle;
      write_first_line(line0);
      pending_rows.delete();
      start_next = 1'b1;
      while (pending_rows.size() < items) queue_entry();
      sent = 0;
      while (pending_rows.size() != 0) begin
         if (with_hold && sent == items / 3) hold_request <= 1'b1;
         send_row(pending_rows.pop_front());
         sent++;
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct  = 18;
      rsp_idle_pct  <= 69;
      write_first_line(32'hFFFF_FFFF);
      foreach (directed_tab[i]) send_row(directed_tab[i]);
      run_phase(280, 32'h0000_0000, 18, 69, 1'b0);
      run_phase(280, 32'($urandom), 69, 18, 1'b0);
      run_phase(270, 32'h8000_0000, 0, 0, 1'b1);
      drain();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // receiver: random stalls plus one long hold that backs up the input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // record scoreboard
   always @(posedge clock) begin : check_records
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_records.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t unexpected record: line %0d..%0d col %0d..%0d cnt %0d", $realtime,
                        rsp_data.start_line, rsp_data.end_line, rsp_data.start_column,
                        rsp_data.end_column, rsp_data.instr_count);
         end else begin
            want = expected_records.pop_front();
            if (rsp_data.start_line   !== want.start_line   ||
                rsp_data.end_line     !== want.end_line     ||
                rsp_data.start_column !== want.start_column ||
                rsp_data.end_column   !== want.end_column   ||
                rsp_data.instr_count  !== want.instr_count  ||
                rsp_data.has_location !== want.has_location ||
                rsp_data.has_columns  !== want.has_columns  ||
                rsp_data.format_error !== want.format_error) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t record mismatch", $realtime);
                  $display("  exp line %0d..%0d col %0d..%0d cnt %0d loc %b cols %b err %b",
                           want.start_line, want.end_line, want.start_column,
                           want.end_column, want.instr_count, want.has_location,
                           want.has_columns, want.format_error);
                  $display("  got line %0d..%0d col %0d..%0d cnt %0d loc %b cols %b err %b",
                           rsp_data.start_line, rsp_data.end_line, rsp_data.start_column,
                           rsp_data.end_column, rsp_data.instr_count, rsp_data.has_location,
                           rsp_data.has_columns, rsp_data.format_error);
               end
            end
         end
      end
   end

   // watchdog: cycles without a beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

`default_nettype wire
